// ===== rtl/page_frame_replacement_macros.svh =====
// Assertion macros shared by the page frame replacement RTL.
`ifndef PAGE_FRAME_REPLACEMENT_MACROS_SVH
`define PAGE_FRAME_REPLACEMENT_MACROS_SVH

// Clocked check that is switched off while reset is held.
`define PFR_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked check that also holds during reset.
`define PFR_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== rtl/pfr_pkg.sv =====
// Shared constants, types and helpers of the page frame replacement block.
package pfr_pkg;

  localparam int NUM_FRAMES = 64;
  localparam int PAGE_BITS  = 20;
  localparam int COUNT_BITS = 16;
  localparam int TIME_BITS  = 32;
  localparam int TOTAL_BITS = 32;
  localparam int IDX_W      = $clog2(NUM_FRAMES);
  localparam int NUM_W      = $clog2(NUM_FRAMES + 1);
  localparam int FRAME_IDX_W = 6;
  localparam int POLICY_W   = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;
  localparam int LFSR_W     = 32;

  localparam logic [LFSR_W-1:0] LFSR_TAPS = 32'h8020_0003;
  localparam logic [LFSR_W-1:0] LFSR_SEED = 32'h0000_0001;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  localparam logic [POLICY_W-1:0] POL_RANDOM = 2'd0;
  localparam logic [POLICY_W-1:0] POL_LRU    = 2'd1;
  localparam logic [POLICY_W-1:0] POL_LFU    = 2'd2;
  localparam logic [POLICY_W-1:0] POL_MFU    = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_POLICY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAMES = 2'd1;

  typedef struct packed {
    logic                  valid;
    logic [PAGE_BITS-1:0]  page;
    logic [TIME_BITS-1:0]  last_use;
    logic [COUNT_BITS-1:0] use_count;
    logic                  dirty;
  } frame_t;

  function automatic logic [LFSR_W-1:0] lfsr_next(input logic [LFSR_W-1:0] s);
    lfsr_next = s[0] ? ((s >> 1) ^ LFSR_TAPS) : (s >> 1);
  endfunction

endpackage

// ===== rtl/pfr_cell.sv =====
// One frame cell of the rotating frame ring.
module pfr_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            shift_i,
  input  pfr_pkg::frame_t frame_i,
  output pfr_pkg::frame_t frame_o
);
  import pfr_pkg::*;

  logic   valid_q;
  frame_t data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (shift_i) begin
      valid_q <= frame_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      data_q <= frame_i;
    end
  end

  always_comb begin
    frame_o       = data_q;
    frame_o.valid = valid_q;
  end

endmodule

// ===== rtl/pfr_mod.sv =====
// Bit-serial remainder unit: one dividend bit per cycle.
module pfr_mod (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [pfr_pkg::LFSR_W-1:0]    dividend_i,
  input  logic [pfr_pkg::NUM_W-1:0]     divisor_i,
  output logic                          done_o,
  output logic [pfr_pkg::NUM_W-1:0]     rem_o
);
  import pfr_pkg::*;

  localparam int STEP_W = $clog2(LFSR_W);

  logic              busy_q, done_q;
  logic [STEP_W-1:0] step_q;
  logic [LFSR_W-1:0] dvd_q;
  logic [NUM_W-1:0]  rem_q, div_q;
  logic [NUM_W:0]    trial;
  logic [NUM_W:0]    rem_next;

  always_comb begin
    trial    = {rem_q, dvd_q[LFSR_W-1]};
    rem_next = (trial >= {1'b0, div_q}) ? trial - {1'b0, div_q} : trial;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + 1'b1;
        if (step_q == STEP_W'(LFSR_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      div_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      dvd_q <= dvd_q << 1;
      rem_q <= rem_next[NUM_W-1:0];
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

// ===== rtl/page_frame_replacement.sv =====
// Top level of the page frame replacement block: sequencer around a rotating frame ring.
//
// Usage. An access item (page number, write flag, timestamp) enters on the
// in channel by valid and ready. One result item per access leaves on the
// out channel: hit, frame index, eviction details and the running fault and
// write-back totals. The policy and frame count registers are written on
// the cfg channel, which is always ready; the user must write them only
// while the block is idle, as the block itself does not enforce it. The
// frames sit in a ring of cells that rotates by one place per cycle while
// the block scans or applies, so frame i is at the head when the position
// counter reads i. A first pass over the ring finds a hit, the first free
// frame and the LRU, LFU or MFU candidate; a decision state follows; a
// second pass updates the chosen frame. A random eviction first draws the
// victim in the bit-serial remainder unit. The next item is taken only
// once the result has been loaded into the output register, so one item is
// in work at a time. Reset empties every frame, seeds the LFSR with one,
// clears both totals and sets the policy to random and the frame count to
// 64. A stalled receiver holds the result in the output register; the next
// item may be accepted meanwhile, but its result waits until the previous
// one is taken.
module page_frame_replacement (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [pfr_pkg::PAGE_BITS-1:0]     page_number_i,
  input  logic                              is_write_i,
  input  logic [pfr_pkg::TIME_BITS-1:0]     access_time_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic                              hit_o,
  output logic [pfr_pkg::FRAME_IDX_W-1:0]   frame_index_o,
  output logic                              evicted_valid_o,
  output logic [pfr_pkg::PAGE_BITS-1:0]     evicted_page_o,
  output logic                              writeback_o,
  output logic [pfr_pkg::TOTAL_BITS-1:0]    faults_seen_o,
  output logic [pfr_pkg::TOTAL_BITS-1:0]    writebacks_seen_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [pfr_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [pfr_pkg::CFG_DATA_W-1:0]    cfg_data_i
);
  import pfr_pkg::*;
`include "page_frame_replacement_macros.svh"

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_PICK  = 3'd2;
  localparam logic [2:0] S_MOD   = 3'd3;
  localparam logic [2:0] S_APPLY = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_FRAMES - 1);

  logic [2:0]            state_q, state_d;
  logic [POLICY_W-1:0]   policy_q;
  logic [CFG_DATA_W-1:0] frames_cfg_q;
  logic [NUM_W-1:0]      n_q;
  logic [IDX_W-1:0]      pos_q, tgt_q;
  logic [PAGE_BITS-1:0]  page_q;
  logic                  wr_q;
  logic [TIME_BITS-1:0]  time_q;
  logic                  hit_found_q, free_found_q, evict_q;
  logic [IDX_W-1:0]      hit_idx_q, free_idx_q, best_idx_q;
  logic [TIME_BITS-1:0]  best_time_q;
  logic [COUNT_BITS-1:0] best_cnt_q;
  logic [LFSR_W-1:0]     lfsr_q;
  logic [TOTAL_BITS-1:0] fault_total_q, wb_total_q;
  logic [PAGE_BITS-1:0]  ev_page_q;
  logic                  wb_q;
  logic                  out_valid_q;

  frame_t ring [NUM_FRAMES];
  frame_t head, tail_d, upd;
  logic   shift, active, better, at_tgt;
  logic   mod_start, mod_done;
  logic [NUM_W-1:0] mod_rem, n_eff;
  logic [LFSR_W-1:0] lfsr_adv;

  // The ring: every cell takes its upper neighbour; the top cell takes the
  // head, possibly rewritten, so a full pass restores the frame order.
  for (genvar k = 0; k < NUM_FRAMES; k++) begin : g_cell
    frame_t cell_in;
    if (k == NUM_FRAMES - 1) begin : g_top
      assign cell_in = tail_d;
    end else begin : g_mid
      assign cell_in = ring[k+1];
    end
    pfr_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (shift),
      .frame_i (cell_in),
      .frame_o (ring[k])
    );
  end

  assign head  = ring[0];
  assign shift = (state_q == S_SCAN) || (state_q == S_APPLY);

  // Zero frames acts as one; more than the ring holds acts as the ring size.
  always_comb begin
    if (frames_cfg_q == '0) begin
      n_eff = NUM_W'(1);
    end else if (NUM_W'(frames_cfg_q) > NUM_W'(NUM_FRAMES)) begin
      n_eff = NUM_W'(NUM_FRAMES);
    end else begin
      n_eff = NUM_W'(frames_cfg_q);
    end
  end

  assign active = {1'b0, pos_q} < n_q;
  assign at_tgt = (state_q == S_APPLY) && (pos_q == tgt_q);

  always_comb begin
    case (policy_q)
      POL_LRU: better = head.last_use < best_time_q;
      POL_LFU: better = head.use_count < best_cnt_q;
      POL_MFU: better = head.use_count > best_cnt_q;
      default: better = 1'b0;
    endcase
  end

  // New contents of the target frame: a refresh on a hit, a fill otherwise.
  always_comb begin
    upd = head;
    upd.last_use = time_q;
    if (hit_found_q) begin
      upd.use_count = (head.use_count == COUNT_MAX) ? head.use_count
                                                    : head.use_count + 1'b1;
      upd.dirty     = head.dirty | wr_q;
    end else begin
      upd.valid     = 1'b1;
      upd.page      = page_q;
      upd.use_count = COUNT_BITS'(1);
      upd.dirty     = wr_q;
    end
    tail_d = at_tgt ? upd : head;
  end

  assign lfsr_adv  = lfsr_next(lfsr_q);
  assign mod_start = (state_q == S_PICK) && !hit_found_q && !free_found_q &&
                     (policy_q == POL_RANDOM);

  pfr_mod u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (mod_start),
    .dividend_i (lfsr_adv),
    .divisor_i  (n_q),
    .done_o     (mod_done),
    .rem_o      (mod_rem)
  );

  assign in_ready_o  = (state_q == S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (in_valid_i) state_d = S_SCAN;
      S_SCAN:  if (pos_q == LAST_IDX) state_d = S_PICK;
      S_PICK:  state_d = mod_start ? S_MOD : S_APPLY;
      S_MOD:   if (mod_done) state_d = S_APPLY;
      S_APPLY: if (pos_q == LAST_IDX) state_d = S_DONE;
      S_DONE:  if (!out_valid_q || out_ready_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      policy_q      <= POL_RANDOM;
      frames_cfg_q  <= CFG_DATA_W'(64);
      lfsr_q        <= LFSR_SEED;
      fault_total_q <= '0;
      wb_total_q    <= '0;
      out_valid_q   <= 1'b0;
      pos_q         <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          REG_POLICY: policy_q     <= cfg_data_i[POLICY_W-1:0];
          REG_FRAMES: frames_cfg_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (shift) begin
        pos_q <= (pos_q == LAST_IDX) ? '0 : pos_q + 1'b1;
      end else begin
        pos_q <= '0;
      end
      if (mod_start) lfsr_q <= lfsr_adv;
      if (at_tgt) begin
        if (!hit_found_q) fault_total_q <= fault_total_q + 1'b1;
        if (evict_q && head.dirty) wb_total_q <= wb_total_q + 1'b1;
      end
      if (state_q == S_DONE && (!out_valid_q || out_ready_i)) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        page_q       <= page_number_i;
        wr_q         <= is_write_i;
        time_q       <= access_time_i;
        n_q          <= n_eff;
        hit_found_q  <= 1'b0;
        free_found_q <= 1'b0;
        evict_q      <= 1'b0;
      end
      S_SCAN: begin
        if (!hit_found_q && active && head.valid && head.page == page_q) begin
          hit_found_q <= 1'b1;
          hit_idx_q   <= pos_q;
        end
        if (!free_found_q && active && !head.valid) begin
          free_found_q <= 1'b1;
          free_idx_q   <= pos_q;
        end
        if (pos_q == '0 || (active && better)) begin
          best_idx_q  <= pos_q;
          best_time_q <= head.last_use;
          best_cnt_q  <= head.use_count;
        end
      end
      S_PICK: begin
        if (hit_found_q) begin
          tgt_q <= hit_idx_q;
        end else if (free_found_q) begin
          tgt_q <= free_idx_q;
        end else begin
          evict_q <= 1'b1;
          tgt_q   <= best_idx_q;
        end
      end
      S_MOD: begin
        if (mod_done) tgt_q <= IDX_W'(mod_rem);
      end
      S_APPLY: begin
        if (at_tgt) begin
          ev_page_q <= evict_q ? head.page : '0;
          wb_q      <= evict_q & head.dirty;
        end
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          hit_o             <= hit_found_q;
          frame_index_o     <= FRAME_IDX_W'(tgt_q);
          evicted_valid_o   <= evict_q;
          evicted_page_o    <= ev_page_q;
          writeback_o       <= wb_q;
          faults_seen_o     <= fault_total_q;
          writebacks_seen_o <= wb_total_q;
        end
      end
      default: ;
    endcase
  end

  `PFR_ASSERT(a_tgt_in_range, (state_q == S_APPLY) |-> ({1'b0, tgt_q} < n_q), "target outside frames in use")
  `PFR_ASSERT(a_mod_range, mod_done |-> (mod_rem < n_q), "random victim not below frame count")
  `PFR_ASSERT(a_hit_no_evict, out_valid_o |-> !(hit_o && evicted_valid_o), "eviction reported on a hit")
  `PFR_ASSERT_ALWAYS(a_wb_needs_evict, out_valid_o && writeback_o |-> evicted_valid_o, "write-back without eviction")

endmodule
